### src/i2cbm_pkg.sv
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2cbm_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;

   // command codes carried in the mode field
   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_STOP  = 3'd1;
   localparam logic [2:0] MODE_WRITE = 3'd2;
   localparam logic [2:0] MODE_READ  = 3'd3;
   localparam logic [2:0] MODE_WACK  = 3'd4;
   localparam logic [2:0] MODE_ACK   = 3'd5;
   localparam logic [2:0] MODE_NACK  = 3'd6;
   localparam logic [2:0] MODE_PROBE = 3'd7;

   // configuration register indexes (byte address bit 2)
   localparam logic REG_PHASE_TICKS      = 1'b0;
   localparam logic REG_READ_PHASE_TICKS = 1'b1;

   localparam logic [15:0] PHASE_TICKS_RESET      = 16'd250;
   localparam logic [15:0] READ_PHASE_TICKS_RESET = 16'd1000;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] data_byte;
      logic       sda_in;
      logic       scl_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_bit;
      logic       bus_fault;
   } rsp_type;

   typedef struct packed {
      logic [15:0] phase_ticks;
      logic [15:0] read_phase_ticks;
   } cfg_type;

endpackage

`default_nettype wire

### src/i2cbm_csr.sv
// Configuration registers of the I2C master bit engine on an APB-style port.
// Depends on i2cbm_pkg.
`default_nettype none

module i2cbm_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output i2cbm_pkg::cfg_type     cfg
);
   import i2cbm_pkg::*;

   logic [15:0] phase_ticks_ff, phase_ticks_in;
   logic [15:0] read_ticks_ff, read_ticks_in;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // word select; byte offset bits are not decoded
   assign reg_sel    = csr_paddr[2];

   // write decode
   always_comb begin
      phase_ticks_in = phase_ticks_ff;
      read_ticks_in  = read_ticks_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_PHASE_TICKS:      phase_ticks_in = csr_pwdata[15:0];
            REG_READ_PHASE_TICKS: read_ticks_in  = csr_pwdata[15:0];
            default:              phase_ticks_in = phase_ticks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
         read_ticks_ff  <= READ_PHASE_TICKS_RESET;
      end else begin
         phase_ticks_ff <= phase_ticks_in;
         read_ticks_ff  <= read_ticks_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         REG_PHASE_TICKS:      csr_prdata = {16'd0, phase_ticks_ff};
         REG_READ_PHASE_TICKS: csr_prdata = {16'd0, read_ticks_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign cfg.phase_ticks      = phase_ticks_ff;
   assign cfg.read_phase_ticks = read_ticks_ff;

endmodule

`default_nettype wire

### src/i2cbm_seq.sv
// Phase sequencer of the I2C master bit engine: command state, phase timer,
// bit counter, shift register and pin levels. Depends on i2cbm_pkg.
`default_nettype none

module i2cbm_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire i2cbm_pkg::req_type req,
   input  wire i2cbm_pkg::cfg_type cfg,
   output i2cbm_pkg::rsp_type     rsp
);
   import i2cbm_pkg::*;

   // phase numbers inside a probe: start, address write, wait ack, stop
   localparam logic [3:0] PROBE_WRITE_BASE = 4'd4;
   localparam logic [3:0] PROBE_WACK_BASE  = 4'd7;
   localparam logic [3:0] PROBE_STOP_BASE  = 4'd10;
   localparam logic [3:0] LAST_STEP        = 4'd12;

   typedef struct packed {
      logic [2:0] m;
      logic [3:0] s;
   } seg_type;

   // map the running command and step to the basic command and its local step
   function automatic seg_type locate(input logic [2:0] amode, input logic [3:0] st);
      seg_type r;
      if (amode != MODE_PROBE) begin
         r.m = amode;            r.s = st;
      end else if (st < PROBE_WRITE_BASE) begin
         r.m = MODE_START;       r.s = st;
      end else if (st < PROBE_WACK_BASE) begin
         r.m = MODE_WRITE;       r.s = st - PROBE_WRITE_BASE;
      end else if (st < PROBE_STOP_BASE) begin
         r.m = MODE_WACK;        r.s = st - PROBE_WACK_BASE;
      end else begin
         r.m = MODE_STOP;        r.s = st - PROBE_STOP_BASE;
      end
      return r;
   endfunction

   function automatic logic [3:0] seg_base(input logic [2:0] m);
      logic [3:0] b;
      unique case (m)
         MODE_WRITE: b = PROBE_WRITE_BASE;
         MODE_WACK:  b = PROBE_WACK_BASE;
         MODE_STOP:  b = PROBE_STOP_BASE;
         default:    b = 4'd0;
      endcase
      return b;
   endfunction

   logic [2:0]  active_mode_ff, active_mode_in;
   logic [3:0]  phase_step_ff, phase_step_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [15:0] wait_timer_ff, wait_timer_in;
   logic        scl_level_ff, scl_level_in;
   logic        sda_level_ff, sda_level_in;
   logic [7:0]  received_byte_ff, received_byte_in;
   logic        ack_level_ff, ack_level_in;
   logic        running_ff, running_in;

   seg_type     end_loc;
   seg_type     beg_loc;
   logic [3:0]  next_s;
   logic        seg_done;
   logic        begin_p;
   logic        read_phase;
   logic [15:0] ticks;
   logic        done;
   logic        fault;

   always_comb begin
      active_mode_in   = active_mode_ff;
      phase_step_in    = phase_step_ff;
      bit_count_in     = bit_count_ff;
      shift_byte_in    = shift_byte_ff;
      wait_timer_in    = wait_timer_ff;
      scl_level_in     = scl_level_ff;
      sda_level_in     = sda_level_ff;
      received_byte_in = received_byte_ff;
      ack_level_in     = ack_level_ff;
      running_in       = running_ff;
      end_loc          = locate(active_mode_ff, phase_step_ff);
      next_s           = end_loc.s + 4'd1;
      seg_done         = 1'b0;
      begin_p          = 1'b0;
      read_phase       = 1'b0;
      done             = 1'b0;
      fault            = 1'b0;

      if (running_ff) begin
         if (wait_timer_ff != 16'd0) begin
            // count down the current phase
            wait_timer_in = wait_timer_ff - 16'd1;
         end else begin
            // close the current phase, sample where needed
            unique case (end_loc.m)
               MODE_START: seg_done = (end_loc.s >= 4'd3);
               MODE_WRITE: begin
                  if (end_loc.s >= 4'd2) begin
                     bit_count_in = bit_count_ff + 4'd1;
                     if (bit_count_in < 4'(BITS_PER_BYTE)) next_s = 4'd0;
                     else seg_done = 1'b1;
                  end
               end
               MODE_READ: begin
                  if (end_loc.s == 4'd0) begin
                     shift_byte_in = {shift_byte_ff[6:0], req.sda_in};
                  end else if (end_loc.s == 4'd1) begin
                     bit_count_in = bit_count_ff + 4'd1;
                     next_s = (bit_count_in < 4'(BITS_PER_BYTE)) ? 4'd0 : 4'd2;
                  end else begin
                     received_byte_in = shift_byte_ff;
                     seg_done = 1'b1;
                  end
               end
               MODE_WACK: begin
                  if (end_loc.s == 4'd1) ack_level_in = req.sda_in;
                  seg_done = (end_loc.s >= 4'd2);
               end
               MODE_ACK: begin
                  if (end_loc.s >= 4'd2) begin
                     sda_level_in = 1'b1;
                     seg_done = 1'b1;
                  end
               end
               default: seg_done = (end_loc.s >= 4'd2);
            endcase

            // advance to the next phase or finish the command
            priority if (!seg_done) begin
               phase_step_in = (active_mode_ff == MODE_PROBE) ?
                               seg_base(end_loc.m) + next_s : next_s;
               begin_p = 1'b1;
            end else if (active_mode_ff != MODE_PROBE || end_loc.m == MODE_STOP) begin
               running_in    = 1'b0;
               phase_step_in = 4'd0;
               done          = 1'b1;
            end else if (end_loc.m == MODE_START) begin
               phase_step_in = PROBE_WRITE_BASE;
               bit_count_in  = 4'd0;
               begin_p       = 1'b1;
            end else begin
               phase_step_in = (end_loc.m == MODE_WRITE) ? PROBE_WACK_BASE
                                                         : PROBE_STOP_BASE;
               begin_p = 1'b1;
            end
         end
      end else if (req.cmd_valid) begin
         // take a new command
         active_mode_in = req.mode;
         phase_step_in  = 4'd0;
         bit_count_in   = 4'd0;
         shift_byte_in  = (req.mode == MODE_WRITE || req.mode == MODE_PROBE) ?
                          req.data_byte : 8'd0;
         if (req.mode == MODE_PROBE && !(req.sda_in && req.scl_in)) begin
            ack_level_in = 1'b1;
            done         = 1'b1;
            fault        = 1'b1;
         end else begin
            if (req.mode == MODE_READ) sda_level_in = 1'b1;
            running_in = 1'b1;
            begin_p    = 1'b1;
         end
      end

      // open the new phase: set pin levels and load the timer
      beg_loc = locate(active_mode_in, phase_step_in);
      if (begin_p) begin
         unique case (beg_loc.m)
            MODE_START: begin
               if (beg_loc.s == 4'd0)      sda_level_in = 1'b1;
               else if (beg_loc.s == 4'd1) scl_level_in = 1'b1;
               else if (beg_loc.s == 4'd2) sda_level_in = 1'b0;
               else                        scl_level_in = 1'b0;
            end
            MODE_STOP: begin
               if (beg_loc.s == 4'd0)      sda_level_in = 1'b0;
               else if (beg_loc.s == 4'd1) scl_level_in = 1'b1;
               else                        sda_level_in = 1'b1;
            end
            MODE_WRITE: begin
               if (beg_loc.s == 4'd0) begin
                  sda_level_in = shift_byte_in[7];
               end else if (beg_loc.s == 4'd1) begin
                  scl_level_in = 1'b1;
               end else begin
                  scl_level_in = 1'b0;
                  // release SDA after the last bit
                  if (bit_count_in == 4'(BITS_PER_BYTE - 1)) sda_level_in = 1'b1;
                  shift_byte_in = {shift_byte_in[6:0], 1'b0};
               end
            end
            MODE_READ: begin
               if (beg_loc.s == 4'd0)      scl_level_in = 1'b1;
               else if (beg_loc.s == 4'd1) scl_level_in = 1'b0;
               read_phase = 1'b1;
            end
            MODE_ACK: begin
               if (beg_loc.s == 4'd0)      sda_level_in = 1'b0;
               else if (beg_loc.s == 4'd1) scl_level_in = 1'b1;
               else                        scl_level_in = 1'b0;
            end
            default: begin
               if (beg_loc.s == 4'd0)      sda_level_in = 1'b1;
               else if (beg_loc.s == 4'd1) scl_level_in = 1'b1;
               else                        scl_level_in = 1'b0;
            end
         endcase
         ticks = read_phase ? cfg.read_phase_ticks : cfg.phase_ticks;
         wait_timer_in = (ticks == 16'd0) ? 16'd0 : ticks - 16'd1;
      end else begin
         ticks = cfg.phase_ticks;
      end
   end

   // hold state between transfers, update on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         active_mode_ff   <= MODE_START;
         phase_step_ff    <= 4'd0;
         bit_count_ff     <= 4'd0;
         shift_byte_ff    <= 8'd0;
         wait_timer_ff    <= 16'd0;
         scl_level_ff     <= 1'b1;
         sda_level_ff     <= 1'b1;
         received_byte_ff <= 8'd0;
         ack_level_ff     <= 1'b1;
         running_ff       <= 1'b0;
      end else if (step_en) begin
         active_mode_ff   <= active_mode_in;
         phase_step_ff    <= phase_step_in;
         bit_count_ff     <= bit_count_in;
         shift_byte_ff    <= shift_byte_in;
         wait_timer_ff    <= wait_timer_in;
         scl_level_ff     <= scl_level_in;
         sda_level_ff     <= sda_level_in;
         received_byte_ff <= received_byte_in;
         ack_level_ff     <= ack_level_in;
         running_ff       <= running_in;
      end
   end

   assign rsp.scl_out   = scl_level_in;
   assign rsp.sda_out   = sda_level_in;
   assign rsp.busy_res  = running_in;
   assign rsp.done_res  = done;
   assign rsp.read_data = received_byte_in;
   assign rsp.ack_bit   = ack_level_in;
   assign rsp.bus_fault = fault;

   // a completed command leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (step_en && done) |=> !running_ff)
      else $error("engine still running after completion");

   // a bus fault only ends a probe that was never started
   a_fault_done: assert property (@(posedge clock) disable iff (reset)
      (step_en && fault) |-> (done && !running_ff && req.mode == MODE_PROBE))
      else $error("bus fault outside a refused probe");

   // the phase timer is empty whenever the engine is idle
   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (wait_timer_ff == 16'd0))
      else $error("phase timer loaded while idle");

   // the step never passes the last probe phase
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      phase_step_ff <= LAST_STEP)
      else $error("phase step out of range");

endmodule

`default_nettype wire

### src/i2c_bit_level_master_unit.sv
// I2C master bit engine, top level: input register, phase sequencer,
// result register and configuration port. Depends on i2cbm_pkg,
// i2cbm_csr and i2cbm_seq.
// Each tick passes the input register, the sequencer and then the result register.
// Throughput: one tick per cycle unless rsp_stall holds the result register.
// Reset clears control state, sets both pins released and loads the tick registers.
`default_nettype none

module i2c_bit_level_master_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire i2cbm_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output i2cbm_pkg::rsp_type      rsp_data,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import i2cbm_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type seq_rsp;
   cfg_type cfg;
   logic    advance;
   logic    out_free;
   logic    in_load;

   i2cbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   i2cbm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (seq_rsp)
   );

   // move a held tick into the result register when it has room
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = req_valid && !req_stall;

   assign in_valid_in  = in_load || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= seq_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
